/* hw/rtl/tdc_pkg.sv */
package tdc_pkg;

  localparam int unsigned CORNER_W = 32;
  localparam int unsigned SLICE_W  = 3;
  localparam int unsigned MASK_W   = 16;

  typedef logic signed [CORNER_W-1:0] corner_t;

  typedef struct packed {
    corner_t bot_z0_x0;
    corner_t bot_z0_x1;
    corner_t bot_z1_x0;
    corner_t bot_z1_x1;
    corner_t top_z0_x0;
    corner_t top_z0_x1;
    corner_t top_z1_x0;
    corner_t top_z1_x1;
  } in_word_t;

  typedef struct packed {
    logic [SLICE_W-1:0] slice_index;
    logic [MASK_W-1:0]  solid_mask;
    logic               last_slice;
  } out_word_t;

endpackage

/* hw/rtl/tdc_edge_cell.sv */
module tdc_edge_cell import tdc_pkg::*; #(
  parameter int unsigned SHIFT = 3
) (
  input  logic    clk,
  input  logic    load,
  input  logic    step,
  input  corner_t bot,
  input  corner_t top,
  output corner_t e_r
);

  localparam int unsigned AW = CORNER_W + 1 + SHIFT;

  corner_t                     a_r;
  logic signed [CORNER_W:0]    diff_r;
  logic signed [AW-1:0]        acc_r;
  logic signed [CORNER_W:0]    diff_nxt;
  logic signed [AW-1:0]        acc_nxt;
  logic signed [AW-1:0]        e_full;
  corner_t                     e_nxt;

  always_comb begin
    diff_nxt = $signed({top[CORNER_W-1], top}) - $signed({bot[CORNER_W-1], bot});
    acc_nxt  = acc_r + $signed({{(AW-CORNER_W-1){diff_r[CORNER_W]}}, diff_r});
    e_full   = $signed({{(AW-CORNER_W){a_r[CORNER_W-1]}}, a_r}) + (acc_r >>> SHIFT);
    e_nxt    = e_full[CORNER_W-1:0];
  end

  // running product diff * ly, one add per slice
  always_ff @(posedge clk) begin
    e_r <= e_nxt;
    if (load) begin
      a_r    <= bot;
      diff_r <= diff_nxt;
      acc_r  <= '0;
    end else if (step) begin
      acc_r  <= acc_nxt;
    end
  end

endmodule

/* hw/rtl/tdc_lerp_cell.sv */
module tdc_lerp_cell import tdc_pkg::*; #(
  parameter int unsigned SHIFT = 2,
  parameter int unsigned T     = 0
) (
  input  logic    clk,
  input  corner_t a,
  input  corner_t b,
  output corner_t y_r
);

  localparam int unsigned PW = CORNER_W + SHIFT + 2;
  localparam logic [SHIFT:0] T_C = (SHIFT+1)'(T);

  logic signed [PW-1:0] diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] y_full;
  corner_t              y_nxt;

  always_comb begin
    diff   = $signed({{(PW-CORNER_W){b[CORNER_W-1]}}, b})
           - $signed({{(PW-CORNER_W){a[CORNER_W-1]}}, a});
    prod   = diff * $signed({{(PW-SHIFT-1){1'b0}}, T_C});
    // arithmetic shift gives the floor for negative products
    y_full = $signed({{(PW-CORNER_W){a[CORNER_W-1]}}, a}) + (prod >>> SHIFT);
    y_nxt  = y_full[CORNER_W-1:0];
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
  end

endmodule

/* hw/rtl/trilinear_density_cell_to_solid_mask.sv */
// channel | ports                     | handshake
// --------+---------------------------+------------------------------------
// input   | start, busy, in_word      | word taken when start && !busy
// result  | out_valid, out_word       | one-cycle strobe, no back-pressure
//
// one cell gives 2^Y_SHIFT slice words, one per cycle; the slice walker counter
// sets that number, and the edge cells step with it.
// the next cell is taken on the cycle of the last slice step, so cells follow
// without gaps. the first slice word passes the edge cells, the row and point
// lerp cells and the output register. busy is high during reset.
// reset clears the walker and the strobe pipe; the receiver cannot stall.
module trilinear_density_cell_to_solid_mask import tdc_pkg::*; #(
  parameter int unsigned Y_SHIFT  = 3,
  parameter int unsigned XZ_SHIFT = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int unsigned NXZ   = 1 << XZ_SHIFT;
  localparam int unsigned NPTS  = NXZ * NXZ;
  localparam int unsigned MBITS = (NPTS < MASK_W) ? NPTS : MASK_W;
  localparam int unsigned NSTG  = 3;
  localparam logic [Y_SHIFT-1:0] LAST_CNT = '1;

  logic               active_r, active_nxt;
  logic [Y_SHIFT-1:0] cnt_r, cnt_nxt;
  logic               accept;

  logic               vld_r  [NSTG];
  logic               last_r [NSTG];
  logic [Y_SHIFT-1:0] ly_r   [NSTG];

  logic               out_valid_r;
  out_word_t          out_word_r;
  logic [MASK_W-1:0]  mask_nxt;

  corner_t e00, e01, e10, e11;
  corner_t r0 [NXZ];
  corner_t r1 [NXZ];
  corner_t d  [NPTS];

  assign busy   = !rst_n || (active_r && (cnt_r != LAST_CNT));
  assign accept = start && !busy;

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
    end else if (active_r) begin
      if (cnt_r == LAST_CNT) begin
        active_nxt = 1'b0;
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // vertical edges
  tdc_edge_cell #(.SHIFT(Y_SHIFT)) u_edge00 (
    .clk(clk), .load(accept), .step(active_r),
    .bot(in_word.bot_z0_x0), .top(in_word.top_z0_x0), .e_r(e00)
  );
  tdc_edge_cell #(.SHIFT(Y_SHIFT)) u_edge01 (
    .clk(clk), .load(accept), .step(active_r),
    .bot(in_word.bot_z0_x1), .top(in_word.top_z0_x1), .e_r(e01)
  );
  tdc_edge_cell #(.SHIFT(Y_SHIFT)) u_edge10 (
    .clk(clk), .load(accept), .step(active_r),
    .bot(in_word.bot_z1_x0), .top(in_word.top_z1_x0), .e_r(e10)
  );
  tdc_edge_cell #(.SHIFT(Y_SHIFT)) u_edge11 (
    .clk(clk), .load(accept), .step(active_r),
    .bot(in_word.bot_z1_x1), .top(in_word.top_z1_x1), .e_r(e11)
  );

  // z rows, then x points
  for (genvar gz = 0; gz < NXZ; gz++) begin : g_row
    tdc_lerp_cell #(.SHIFT(XZ_SHIFT), .T(gz)) u_row0 (
      .clk(clk), .a(e00), .b(e10), .y_r(r0[gz])
    );
    tdc_lerp_cell #(.SHIFT(XZ_SHIFT), .T(gz)) u_row1 (
      .clk(clk), .a(e01), .b(e11), .y_r(r1[gz])
    );
    for (genvar gx = 0; gx < NXZ; gx++) begin : g_pt
      tdc_lerp_cell #(.SHIFT(XZ_SHIFT), .T(gx)) u_pt (
        .clk(clk), .a(r0[gz]), .b(r1[gz]), .y_r(d[gz*NXZ+gx])
      );
    end
  end

  always_comb begin
    mask_nxt = '0;
    for (int i = 0; i < MBITS; i++) begin
      mask_nxt[i] = (d[i] > 0);
    end
  end

  // slice tags ride alongside the lerp stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) begin
        vld_r[s] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= active_r;
      for (int s = 1; s < NSTG; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    ly_r[0]   <= cnt_r;
    last_r[0] <= (cnt_r == LAST_CNT);
    for (int s = 1; s < NSTG; s++) begin
      ly_r[s]   <= ly_r[s-1];
      last_r[s] <= last_r[s-1];
    end
    out_word_r.slice_index <= SLICE_W'(ly_r[NSTG-1]);
    out_word_r.solid_mask  <= mask_nxt;
    out_word_r.last_slice  <= last_r[NSTG-1];
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_first_slice: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 (out_valid && out_word.slice_index == '0))
    else $error("first slice word missing after cell taken");

  a_slices_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.last_slice) |=> out_valid)
    else $error("gap inside a cell's slice words");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last_slice) |-> (out_word.slice_index == SLICE_W'(LAST_CNT)))
    else $error("last slice flag on wrong slice");

  a_busy_active: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> active_r)
    else $error("busy while walker idle");

endmodule
